// ===== src/htfl_pkg.sv =====
package htfl_pkg;

    // default table depth
    localparam int unsigned ENTRIES_DEFAULT = 4096;

    localparam int unsigned MODE_W    = 2;
    localparam int unsigned HANDLE_W  = 16;
    localparam int unsigned PAYLOAD_W = 64;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned NEWH_W    = 12;

    typedef enum logic [MODE_W-1:0] {
        MODE_FIND  = 2'd0,
        MODE_ALLOC = 2'd1,
        MODE_FREE  = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_DOWN      = 3'd1,
        ST_BADHANDLE = 3'd2,
        ST_NOTUSED   = 3'd3,
        ST_EXHAUSTED = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;   // latch transaction, issue table read
        logic exec;     // table data ready, update state and load result
    } t_cmd;

endpackage

// ===== src/handle_table_free_list_core.sv =====
// handle table with a lifo free list: each transaction is a find, an alloc
// or a free (an undefined mode answers as a bad handle) and gives exactly
// one result. accept latches it and issues the synchronous table read;
// execute evaluates the entry, writes it back, moves the free head and
// loads the output register. no new transaction is taken until the last
// one has executed, but the next is taken while the last result still
// waits downstream. handle 0 is never valid; index ENTRIES-1 is never
// handed out, and an alloc that runs out of entries takes the block down
// until reset. there is no clearing pass after reset: a high-water mark
// marks which entries were ever written, so the table is usable at once.
module handle_table_free_list_core #(
    parameter int unsigned ENTRIES = htfl_pkg::ENTRIES_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [htfl_pkg::MODE_W-1:0]        i_mode,
    input  logic [htfl_pkg::HANDLE_W-1:0]      i_handle,
    input  logic [htfl_pkg::PAYLOAD_W-1:0]     i_payload,
    // result channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [htfl_pkg::STATUS_W-1:0]      o_status,
    output logic [htfl_pkg::NEWH_W-1:0]        o_new_handle,
    output logic [htfl_pkg::PAYLOAD_W-1:0]     o_found_value
);

    // command bundle from the sequencer
    htfl_pkg::t_cmd cmd;

    // sequencer: idle/exec plus the output valid flag
    htfl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    // table memory, free head, high-water mark and result register
    htfl_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_mode        (i_mode),
        .i_handle      (i_handle),
        .i_payload     (i_payload),
        .o_status      (o_status),
        .o_new_handle  (o_new_handle),
        .o_found_value (o_found_value)
    );

    // a taken transaction blocks the request side while it waits to execute
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> o_stall)
        else $error("request side not stalled after a transaction was taken");

    // execute always leaves a result on the output
    a_result_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |=> o_valid)
        else $error("no result after execute");

    // taking a transaction and executing one never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.accept && cmd.exec))
        else $error("accept and execute in the same cycle");

endmodule

// ===== src/htfl_ctrl.sv =====
module htfl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    output htfl_pkg::t_cmd     o_cmd
);

    htfl_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    always_comb begin
        o_cmd.accept = (r_state == htfl_pkg::S_IDLE) && i_valid;
        o_cmd.exec   = (r_state == htfl_pkg::S_EXEC) && (!r_out_valid || !i_stall);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            htfl_pkg::S_IDLE: begin
                if (o_cmd.accept) begin
                    n_state = htfl_pkg::S_EXEC;
                end
            end
            htfl_pkg::S_EXEC: begin
                if (o_cmd.exec) begin
                    n_state = htfl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = htfl_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= htfl_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != htfl_pkg::S_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ===== src/htfl_dp.sv =====
module htfl_dp #(
    parameter int unsigned ENTRIES = htfl_pkg::ENTRIES_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  htfl_pkg::t_cmd                     i_cmd,
    input  logic [htfl_pkg::MODE_W-1:0]        i_mode,
    input  logic [htfl_pkg::HANDLE_W-1:0]      i_handle,
    input  logic [htfl_pkg::PAYLOAD_W-1:0]     i_payload,
    output logic [htfl_pkg::STATUS_W-1:0]      o_status,
    output logic [htfl_pkg::NEWH_W-1:0]        o_new_handle,
    output logic [htfl_pkg::PAYLOAD_W-1:0]     o_found_value
);

    localparam int unsigned IW = $clog2(ENTRIES);
    localparam int unsigned PW = htfl_pkg::PAYLOAD_W;
    localparam int unsigned HW = htfl_pkg::HANDLE_W;
    localparam int unsigned NW = htfl_pkg::NEWH_W;

    // table: {used, word}
    logic [PW:0]   r_mem [ENTRIES];
    logic [PW:0]   r_rd;

    logic [IW-1:0] r_head, n_head;
    // entries at or above the high-water mark were never written
    logic [IW-1:0] r_hwm, n_hwm;

    logic [htfl_pkg::MODE_W-1:0] r_mode;
    logic [IW-1:0]               r_addr;
    logic                        r_bad;
    logic [PW-1:0]               r_pay;

    logic [IW+HW-1:0] h_ext;
    logic [IW-1:0]    h_idx;
    logic             h_bad;

    always_comb begin
        h_ext = {{IW{1'b0}}, i_handle};
        h_idx = h_ext[IW-1:0];
        h_bad = (i_handle == '0) || (h_ext >= (IW+HW)'(ENTRIES));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= i_mode;
            r_bad  <= h_bad;
            r_pay  <= i_payload;
            if (i_mode == htfl_pkg::MODE_ALLOC) begin
                r_addr <= r_head;
            end else begin
                r_addr <= h_idx;
            end
        end
    end

    // execute stage
    logic          ent_valid;
    logic          ent_used;
    logic [PW-1:0] ent_word;
    logic [IW-1:0] link;
    logic [IW:0]   nxt;
    logic          down;
    logic          mem_we;
    logic [PW:0]   mem_wd;
    logic [IW+NW-1:0]          addr_ext;
    htfl_pkg::t_status         res_status;
    logic [NW-1:0]             res_nh;
    logic [PW-1:0]             res_fv;

    always_comb begin
        ent_valid = (r_addr < r_hwm);
        ent_used  = ent_valid && r_rd[PW];
        ent_word  = ent_valid ? r_rd[PW-1:0] : '0;
        if (ent_used || (ent_word >= PW'(ENTRIES))) begin
            link = '0;
        end else begin
            link = ent_word[IW-1:0];
        end
        if (link == '0) begin
            nxt = {1'b0, r_addr} + (IW+1)'(1);
        end else begin
            nxt = {1'b0, link};
        end
        down     = (r_head == '0);
        addr_ext = {{NW{1'b0}}, r_addr};

        res_status = htfl_pkg::ST_OK;
        res_nh     = '0;
        res_fv     = '0;
        n_head     = r_head;
        n_hwm      = r_hwm;
        mem_we     = 1'b0;
        mem_wd     = {1'b1, r_pay};

        if (down) begin
            res_status = htfl_pkg::ST_DOWN;
        end else begin
            case (r_mode)
                htfl_pkg::MODE_FIND: begin
                    if (r_bad) begin
                        res_status = htfl_pkg::ST_BADHANDLE;
                    end else if (!ent_used) begin
                        res_status = htfl_pkg::ST_NOTUSED;
                    end else begin
                        res_fv = ent_word;
                    end
                end
                htfl_pkg::MODE_ALLOC: begin
                    if (nxt >= (IW+1)'(ENTRIES)) begin
                        n_head     = '0;
                        res_status = htfl_pkg::ST_EXHAUSTED;
                    end else begin
                        n_head = nxt[IW-1:0];
                        mem_we = 1'b1;
                        mem_wd = {1'b1, r_pay};
                        res_nh = addr_ext[NW-1:0];
                        if (!ent_valid) begin
                            n_hwm = nxt[IW-1:0];
                        end
                    end
                end
                htfl_pkg::MODE_FREE: begin
                    if (r_bad) begin
                        res_status = htfl_pkg::ST_BADHANDLE;
                    end else if (!ent_used) begin
                        res_status = htfl_pkg::ST_NOTUSED;
                    end else begin
                        mem_we = 1'b1;
                        mem_wd = {1'b0, PW'(r_head)};
                        n_head = r_addr;
                    end
                end
                default: begin
                    res_status = htfl_pkg::ST_BADHANDLE;
                end
            endcase
        end
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && mem_we) begin
            r_mem[r_addr] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            if (i_mode == htfl_pkg::MODE_ALLOC) begin
                r_rd <= r_mem[r_head];
            end else begin
                r_rd <= r_mem[h_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= IW'(1);
            r_hwm  <= '0;
        end else if (i_cmd.exec) begin
            r_head <= n_head;
            r_hwm  <= n_hwm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_status      <= res_status;
            o_new_handle  <= res_nh;
            o_found_value <= res_fv;
        end
    end

endmodule

// ===== test/tb_handle_table_free_list_core.sv =====
module tb_handle_table_free_list_core;

    localparam int unsigned ENTRIES       = htfl_pkg::ENTRIES_DEFAULT;
    localparam int unsigned IW            = $clog2(ENTRIES);
    // the fourth mode code is undefined and answers as a bad handle
    localparam logic [htfl_pkg::MODE_W-1:0] MODE_UNKNOWN = 2'd3;
    localparam int unsigned MAX_GAP       = 17;
    localparam int unsigned RANDOM_OPS    = 1270;
    localparam int unsigned HOLD_AT       = 400;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned REPORT_LIMIT  = 10;

    // one request transaction plus the idle cycles the sender spends before it
    typedef struct {
        logic [htfl_pkg::MODE_W-1:0]    mode;
        logic [htfl_pkg::HANDLE_W-1:0]  handle;
        logic [htfl_pkg::PAYLOAD_W-1:0] payload;
        int unsigned                    gap;
    } t_request;

    typedef struct {
        logic [htfl_pkg::STATUS_W-1:0]  status;
        logic [htfl_pkg::NEWH_W-1:0]    new_handle;
        logic [htfl_pkg::PAYLOAD_W-1:0] found_value;
    } t_outcome;

    // dut ports; the driven inputs are known from time zero
    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_valid       = 1'b0;
    logic                           o_stall;
    logic [htfl_pkg::MODE_W-1:0]    i_mode        = '0;
    logic [htfl_pkg::HANDLE_W-1:0]  i_handle      = '0;
    logic [htfl_pkg::PAYLOAD_W-1:0] i_payload     = '0;
    logic                           o_valid;
    logic                           i_stall       = 1'b0;
    logic [htfl_pkg::STATUS_W-1:0]  o_status;
    logic [htfl_pkg::NEWH_W-1:0]    o_new_handle;
    logic [htfl_pkg::PAYLOAD_W-1:0] o_found_value;

    // shadow of the handle table, updated when a request is accepted
    int unsigned                    tbl_head;
    logic [htfl_pkg::PAYLOAD_W-1:0] tbl_word [ENTRIES];
    bit                             tbl_used [ENTRIES];
    // handles currently holding a payload, used to aim finds and frees
    int unsigned          live_handles[$];
    int unsigned          last_freed = 1;

    t_request             queued_requests[$];
    t_outcome             awaited_results[$];

    int unsigned          tx_idle       = 0;
    bit                   tx_burst      = 1'b0;
    int unsigned          rx_wait       = 0;
    bit                   rx_burst      = 1'b0;
    int unsigned          results_seen  = 0;
    logic                 long_hold     = 1'b0;
    int unsigned          hold_count    = 0;
    bit                   hold_done     = 1'b0;
    int unsigned          fail_count    = 0;
    int unsigned          cycle_count   = 0;

    handle_table_free_list_core #(
        .ENTRIES(ENTRIES)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_handle     (i_handle),
        .i_payload    (i_payload),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_new_handle (o_new_handle),
        .o_found_value(o_found_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // apply one accepted transaction to the shadow table and return its result
    function automatic t_outcome apply_table_op(t_request rq);
        t_outcome                       res;
        int unsigned                    idx;
        int unsigned                    succ;
        logic [htfl_pkg::PAYLOAD_W-1:0] lnk;
        logic [IW-1:0]                  hix;
        logic [IW-1:0]                  aix;
        res.status      = htfl_pkg::ST_OK;
        res.new_handle  = '0;
        res.found_value = '0;
        hix             = rq.handle[IW-1:0];
        if (tbl_head == 0 || tbl_head >= ENTRIES) begin
            // down after exhaustion: nothing moves until reset
            res.status = htfl_pkg::ST_DOWN;
        end else if (rq.mode == htfl_pkg::MODE_FIND || rq.mode == htfl_pkg::MODE_FREE) begin
            if (rq.handle == 0 || rq.handle >= ENTRIES) begin
                res.status = htfl_pkg::ST_BADHANDLE;
            end else if (!tbl_used[hix]) begin
                // also catches a double free
                res.status = htfl_pkg::ST_NOTUSED;
            end else if (rq.mode == htfl_pkg::MODE_FIND) begin
                res.found_value = tbl_word[hix];
            end else begin
                // push onto the lifo: the word now links to the old head
                tbl_word[hix] = htfl_pkg::PAYLOAD_W'(tbl_head);
                tbl_used[hix] = 1'b0;
                tbl_head      = 32'(rq.handle);
                last_freed    = 32'(rq.handle);
                for (int k = 0; k < live_handles.size(); k++) begin
                    if (live_handles[k] == 32'(rq.handle)) begin
                        live_handles.delete(k);
                        break;
                    end
                end
            end
        end else if (rq.mode == htfl_pkg::MODE_ALLOC) begin
            idx = tbl_head;
            aix = idx[IW-1:0];
            lnk = tbl_word[aix];
            // a link out of range is taken as zero
            if (tbl_used[aix] || lnk >= ENTRIES)
                lnk = '0;
            // zero link means the next fresh index
            if (lnk == 0)
                succ = idx + 1;
            else
                succ = lnk[31:0];
            if (succ >= ENTRIES) begin
                tbl_head   = 0;
                res.status = htfl_pkg::ST_EXHAUSTED;
            end else begin
                tbl_head       = succ;
                tbl_word[aix]  = rq.payload;
                tbl_used[aix]  = 1'b1;
                res.new_handle = idx[htfl_pkg::NEWH_W-1:0];
                live_handles.push_back(idx);
            end
        end else begin
            res.status = htfl_pkg::ST_BADHANDLE;
        end
        return res;
    endfunction

    function automatic void note_failure(string msg);
        if (fail_count < REPORT_LIMIT)
            $display("%s", msg);
        fail_count++;
    endfunction

    // queue one transaction for the driver, keeping the queue short so that
    // handles picked from the live list are close to the real table state
    task automatic offer(logic [htfl_pkg::MODE_W-1:0] mode,
                         logic [htfl_pkg::HANDLE_W-1:0] handle,
                         logic [htfl_pkg::PAYLOAD_W-1:0] payload);
        t_request rq;
        rq.mode    = mode;
        rq.handle  = handle;
        rq.payload = payload;
        rq.gap     = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        queued_requests.push_back(rq);
        while (queued_requests.size() >= 2)
            @(negedge i_clk);
    endtask

    // driver: a transaction moves when valid is high and stall is low;
    // a stalled payload is held, a free slot takes the next queued request
    // once its idle gap has run out
    always @(posedge i_clk) begin : drive_requests
        t_request taken;
        t_request upcoming;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            tx_idle  <= 0;
            tbl_head = 1;
            foreach (tbl_word[k]) begin
                tbl_word[k] = '0;
                tbl_used[k] = 1'b0;
            end
            live_handles.delete();
        end else begin
            if (i_valid && !o_stall) begin
                taken.mode    = i_mode;
                taken.handle  = i_handle;
                taken.payload = i_payload;
                taken.gap     = 0;
                awaited_results.push_back(apply_table_op(taken));
            end
            if (!i_valid || !o_stall) begin
                if (queued_requests.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (tx_idle < queued_requests[0].gap) begin
                    i_valid <= 1'b0;
                    tx_idle <= tx_idle + 1;
                end else begin
                    upcoming  = queued_requests.pop_front();
                    i_valid   <= 1'b1;
                    i_mode    <= upcoming.mode;
                    i_handle  <= upcoming.handle;
                    i_payload <= upcoming.payload;
                    tx_idle   <= 0;
                end
            end
        end
    end

    // monitor: check every result transaction against the oldest prediction,
    // then draw how long to stall before taking the next one
    always @(posedge i_clk) begin : check_results
        t_outcome    want;
        int unsigned draw;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_wait <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen <= results_seen + 1;
                // switch between stalling and full-rate stretches now and then
                if (results_seen % 50 == 49)
                    rx_burst <= ($urandom_range(0, 3) == 0);
                if (awaited_results.size() == 0) begin
                    note_failure($sformatf(
                        "unexpected result: status %0d new_handle %0d found_value %h",
                        o_status, o_new_handle, o_found_value));
                end else begin
                    want = awaited_results.pop_front();
                    if (want.status !== o_status || want.new_handle !== o_new_handle ||
                        want.found_value !== o_found_value)
                        note_failure($sformatf(
                            "result %0d mismatch (expected/actual): status %0d/%0d %s%0d/%0d %s%h/%h",
                            results_seen, want.status, o_status,
                            "new_handle ", want.new_handle, o_new_handle,
                            "found_value ", want.found_value, o_found_value));
                end
                draw = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
                rx_wait <= draw;
                i_stall <= (draw != 0) || long_hold;
            end else if (rx_wait != 0) begin
                rx_wait <= rx_wait - 1;
                i_stall <= (rx_wait > 1) || long_hold;
            end else begin
                i_stall <= long_hold;
            end
        end
    end

    // one long receiver hold-off so the block backs up and stalls its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            long_hold  <= 1'b0;
            hold_count <= 0;
            hold_done  <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            if (hold_count == HOLD_CYCLES) begin
                long_hold <= 1'b0;
                hold_done <= 1'b1;
            end else begin
                long_hold  <= 1'b1;
                hold_count <= hold_count + 1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned pick;
        logic [htfl_pkg::MODE_W-1:0] rmode;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: bad handles and unused entries on an empty table
        offer(htfl_pkg::MODE_FIND, '0, '0);
        offer(htfl_pkg::MODE_FIND, 16'd1, '0);
        offer(htfl_pkg::MODE_FREE, 16'd1, '1);
        offer(htfl_pkg::MODE_FREE, '1, '0);
        offer(htfl_pkg::MODE_FIND, htfl_pkg::HANDLE_W'(ENTRIES), '0);
        offer(MODE_UNKNOWN, 16'd1, '1);
        // fresh allocs come out in order from the frontier
        offer(htfl_pkg::MODE_ALLOC, '1, '1);
        offer(htfl_pkg::MODE_ALLOC, '0, '0);
        offer(htfl_pkg::MODE_ALLOC, '0, 64'h8000_0000_0000_0001);
        offer(htfl_pkg::MODE_FIND, 16'd1, '0);
        offer(htfl_pkg::MODE_FIND, 16'd2, '1);
        offer(htfl_pkg::MODE_FIND, htfl_pkg::HANDLE_W'(ENTRIES - 1), '0);
        // free then double free, and lifo reuse of the freed entry
        offer(htfl_pkg::MODE_FREE, 16'd2, '0);
        offer(htfl_pkg::MODE_FREE, 16'd2, '0);
        offer(htfl_pkg::MODE_FIND, 16'd2, '0);
        offer(htfl_pkg::MODE_ALLOC, '0, 64'hA5A5_5A5A_C3C3_3C3C);
        // build a linked free list, then drain it back through the links
        offer(htfl_pkg::MODE_FREE, 16'd1, '0);
        offer(htfl_pkg::MODE_FREE, 16'd3, '0);
        offer(htfl_pkg::MODE_ALLOC, '0, 64'h0123_4567_89AB_CDEF);
        offer(htfl_pkg::MODE_ALLOC, '0, 64'hFEDC_BA98_7654_3210);
        offer(htfl_pkg::MODE_ALLOC, '0, 64'h0000_0000_FFFF_FFFF);
        offer(htfl_pkg::MODE_FIND, 16'd3, '0);

        // random: mostly allocs and finds/frees of live handles, some noise
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 60 == 0)
                tx_burst = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 38 || (live_handles.size() == 0 && pick < 82))
                offer(htfl_pkg::MODE_ALLOC, htfl_pkg::HANDLE_W'($urandom),
                      {$urandom, $urandom});
            else if (pick < 60)
                offer(htfl_pkg::MODE_FREE,
                      htfl_pkg::HANDLE_W'(live_handles[$urandom_range(0,
                                          live_handles.size() - 1)]),
                      {$urandom, $urandom});
            else if (pick < 82)
                offer(htfl_pkg::MODE_FIND,
                      htfl_pkg::HANDLE_W'(live_handles[$urandom_range(0,
                                          live_handles.size() - 1)]),
                      {$urandom, $urandom});
            else if (pick < 86)
                // likely a double free or a find of a freed entry
                offer($urandom_range(0, 1) ? htfl_pkg::MODE_FREE : htfl_pkg::MODE_FIND,
                      htfl_pkg::HANDLE_W'(last_freed), {$urandom, $urandom});
            else if (pick < 91)
                offer($urandom_range(0, 1) ? htfl_pkg::MODE_FREE : htfl_pkg::MODE_FIND,
                      $urandom_range(0, 1) ? '0 :
                          htfl_pkg::HANDLE_W'($urandom_range(ENTRIES, 65535)),
                      {$urandom, $urandom});
            else if (pick < 95) begin
                rmode = htfl_pkg::MODE_W'($urandom);
                offer(rmode, htfl_pkg::HANDLE_W'($urandom), {$urandom, $urandom});
            end else
                offer($urandom_range(0, 1) ? htfl_pkg::MODE_FREE : htfl_pkg::MODE_FIND,
                      htfl_pkg::HANDLE_W'($urandom_range(1, ENTRIES - 1)),
                      {$urandom, $urandom});
        end

        // a last mix of every mode on whatever state the table is in
        offer(htfl_pkg::MODE_FIND, 16'd1, '0);
        offer(htfl_pkg::MODE_FREE, 16'd1, '0);
        offer(htfl_pkg::MODE_FIND, '0, '0);
        offer(MODE_UNKNOWN, '1, '1);
        offer(htfl_pkg::MODE_ALLOC, '0, '1);

        // let everything drain, then allow a few more cycles for strays
        while (queued_requests.size() != 0 || i_valid)
            @(negedge i_clk);
        while (awaited_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && awaited_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/htfl_pkg.sv
src/htfl_ctrl.sv
src/htfl_dp.sv
src/handle_table_free_list_core.sv
test/tb_handle_table_free_list_core.sv
